/* rtl/lgs_pkg.sv */
// Shared types and constants for the Life generation step unit.
`timescale 1ns / 1ps
package lgs_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 4096;
  localparam int ROW_W    = 12;   // row index width
  localparam int RC_W     = 13;   // row_count register width
  localparam int CC_W     = 7;    // column_count register width
  localparam int CFG_IW   = 1;    // configuration index width
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [CFG_IW-1:0] CFG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_COLUMN_COUNT = 1'd1;

  localparam logic [RC_W-1:0] ROW_COUNT_RESET    = RC_W'(64);
  localparam logic [CC_W-1:0] COLUMN_COUNT_RESET = CC_W'(64);

  // Masked bits of one column that a cell shows to its neighbors.
  typedef struct packed {
    logic up;   // row two back
    logic mid;  // previous row
    logic dn;   // incoming row
  } nbr_t;

  // Per-transaction control broadcast to every cell.
  typedef struct packed {
    logic load;   // input transaction this cycle
    logic first;  // incoming row is row 0 of a grid
    logic last;   // incoming row is the final row
  } cell_ctl_t;

  // One result entry.
  typedef struct packed {
    logic [MAX_COLS-1:0] next_cells;
    logic [ROW_W-1:0]    out_row;
    logic                grid_done;
  } result_t;

  // Push request into the result queue; entry a goes ahead of entry b.
  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

  function automatic logic life_rule(input logic alive, input logic [3:0] n);
    life_rule = (n == 4'd3) || (alive && (n == 4'd2));
  endfunction

endpackage

/* rtl/life_generation_step_unit.sv */
// Top level of the Life generation step unit: cell row, row tracking, result queue.
`timescale 1ns / 1ps
// One generation of Conway Life (birth on 3, survival on 2 or 3) over a bounded
// grid whose outside is dead. Rows stream in on the in_ channel, one 64-bit row
// per transaction, bit c for column c. A row of 64 column cells holds the two
// previous rows; each row after the first of a grid releases the next
// generation of the row above it, and the final row (index row_count-1) also
// releases its own next generation, so it yields two results in order. A row
// is taken every cycle while the queue has room for two results: the cells
// evaluate both candidate rows combinationally and the results are registered
// into a four-entry queue that drives the out_ channel, the final row's own
// result after that of the row above. The first row of a grid releases nothing
// and the final row releases two, so a grid of N rows gives N results and the
// out_ channel keeps pace with back-to-back input; in_tready drops only while
// the queue has fewer than two free entries. Results carry the row index on
// out_tuser and mark the final row with out_tlast. Bits at or beyond
// column_count are forced dead on input and read back as zero. Write row_count
// (index 0) and column_count (index 1) only while no results are pending; zero
// counts act as one, counts above the limits saturate (column_count keeps only
// the low 7 bits written), and after the final row a new grid starts at row 0.
module life_generation_step_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // input rows
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [lgs_pkg::MAX_COLS-1:0] in_tdata,   // [63:0] row_cells
  // results
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lgs_pkg::MAX_COLS-1:0] out_tdata,  // [63:0] next_cells
  output logic [lgs_pkg::ROW_W-1:0]  out_tuser,    // [11:0] out_row
  output logic                       out_tlast,    // grid_done
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lgs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [lgs_pkg::RC_W-1:0]   cfg_data
);
  import lgs_pkg::*;

  logic [RC_W-1:0]  row_count_r;
  logic [CC_W-1:0]  column_count_r;
  logic [ROW_W-1:0] rows_seen_r, rows_seen_nxt;

  logic [RC_W-1:0]  rows_eff;
  logic [ROW_W-1:0] last_idx;
  logic [CC_W-1:0]  cols_eff;
  logic             accept;
  logic             room2;
  cell_ctl_t        ctl;
  push_t            push;
  result_t          res_a, res_b, head;

  logic [MAX_COLS-1:0] col_en, next_a, next_b;
  nbr_t                nbr [MAX_COLS];

  // Configuration is always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RESET;
      column_count_r <= COLUMN_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_COUNT:    row_count_r    <= cfg_data;
        CFG_COLUMN_COUNT: column_count_r <= cfg_data[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts into their legal ranges.
  always_comb begin
    rows_eff = row_count_r;
    if (rows_eff == '0) rows_eff = RC_W'(1);
    if (rows_eff > RC_W'(MAX_ROWS)) rows_eff = RC_W'(MAX_ROWS);
    cols_eff = column_count_r;
    if (cols_eff == '0) cols_eff = CC_W'(1);
    if (cols_eff > CC_W'(MAX_COLS)) cols_eff = CC_W'(MAX_COLS);
  end

  assign last_idx = ROW_W'(rows_eff - RC_W'(1));

  assign in_tready = room2;
  assign accept    = in_tvalid & in_tready;

  assign ctl.load  = accept;
  assign ctl.first = (rows_seen_r == '0);
  assign ctl.last  = (rows_seen_r >= last_idx);

  // Advance the stream position; wrap to a fresh grid after the final row.
  always_comb begin
    rows_seen_nxt = rows_seen_r;
    if (accept) rows_seen_nxt = ctl.last ? '0 : rows_seen_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rows_seen_r <= '0;
    else        rows_seen_r <= rows_seen_nxt;
  end

  // Row of column cells; each sees the masked bits of its two neighbors.
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    nbr_t left_n, right_n;
    assign col_en[c] = (CC_W'(c) < cols_eff);
    if (c == 0) begin : g_l0
      assign left_n = '0;
    end else begin : g_l
      assign left_n = nbr[c-1];
    end
    if (c == MAX_COLS - 1) begin : g_r0
      assign right_n = '0;
    end else begin : g_r
      assign right_n = nbr[c+1];
    end
    lgs_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .col_en (col_en[c]),
      .in_bit (in_tdata[c]),
      .left   (left_n),
      .right  (right_n),
      .own    (nbr[c]),
      .next_a (next_a[c]),
      .next_b (next_b[c])
    );
  end

  // Entry a: row above the incoming one; entry b: the final row itself.
  assign push.push_a = accept & ~ctl.first;
  assign push.push_b = accept & ctl.last;

  assign res_a.next_cells = next_a;
  assign res_a.out_row    = rows_seen_r - 1'b1;
  assign res_a.grid_done  = 1'b0;
  assign res_b.next_cells = next_b;
  assign res_b.out_row    = rows_seen_r;
  assign res_b.grid_done  = 1'b1;

  lgs_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .din_a      (res_a),
    .din_b      (res_b),
    .room2      (room2),
    .dout_valid (out_tvalid),
    .dout_ready (out_tready),
    .dout       (head)
  );

  assign out_tdata = head.next_cells;
  assign out_tuser = head.out_row;
  assign out_tlast = head.grid_done;

endmodule

/* rtl/lgs_cell.sv */
// One column cell: holds two row bits and evaluates both candidate next states.
`timescale 1ns / 1ps
module lgs_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  lgs_pkg::cell_ctl_t ctl,
  input  logic             col_en,
  input  logic             in_bit,
  input  lgs_pkg::nbr_t    left,
  input  lgs_pkg::nbr_t    right,
  output lgs_pkg::nbr_t    own,
  output logic             next_a,
  output logic             next_b
);
  import lgs_pkg::*;

  logic above_r, above_nxt;
  logic mid_r, mid_nxt;
  logic [3:0] cnt_a, cnt_b;
  logic up_b;

  assign own.up  = above_r & col_en;
  assign own.mid = mid_r & col_en;
  assign own.dn  = in_bit & col_en;

  // Window for the row above the incoming one.
  assign cnt_a = 4'(left.up) + 4'(own.up) + 4'(right.up)
               + 4'(left.mid) + 4'(right.mid)
               + 4'(left.dn) + 4'(own.dn) + 4'(right.dn);
  assign next_a = col_en & life_rule(own.mid, cnt_a);

  // Window for the incoming row itself, dead row below.
  assign up_b  = ~ctl.first;
  assign cnt_b = 4'(left.mid & up_b) + 4'(own.mid & up_b) + 4'(right.mid & up_b)
               + 4'(left.dn) + 4'(right.dn);
  assign next_b = col_en & life_rule(own.dn, cnt_b);

  // Shift the held bits on each load, clearing them after the final row; the incoming bit is stored masked.
  always_comb begin
    above_nxt = above_r;
    mid_nxt   = mid_r;
    if (ctl.load) begin
      if (ctl.last) begin
        above_nxt = 1'b0;
        mid_nxt   = 1'b0;
      end else begin
        above_nxt = ctl.first ? 1'b0 : mid_r;
        mid_nxt   = own.dn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r <= 1'b0;
      mid_r   <= 1'b0;
    end else begin
      above_r <= above_nxt;
      mid_r   <= mid_nxt;
    end
  end

endmodule

/* rtl/lgs_out_fifo.sv */
// Small result queue: takes up to two entries per cycle, gives one while dout_ready is high.
`timescale 1ns / 1ps
module lgs_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  lgs_pkg::push_t    push,
  input  lgs_pkg::result_t  din_a,
  input  lgs_pkg::result_t  din_b,
  output logic              room2,
  output logic              dout_valid,
  input  logic              dout_ready,
  output lgs_pkg::result_t  dout
);
  import lgs_pkg::*;

  result_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic [FIFO_AW-1:0] addr_b;
  logic pop;

  assign dout_valid = (cnt_r != '0);
  assign dout       = mem[rd_r];
  assign pop        = dout_valid & dout_ready;
  assign room2      = (cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign addr_b     = push.push_a ? wr_r + 1'b1 : wr_r;

  always_comb begin
    wr_nxt  = wr_r + FIFO_AW'(push.push_a) + FIFO_AW'(push.push_b);
    rd_nxt  = rd_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + FIFO_CW'(push.push_a) + FIFO_CW'(push.push_b) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push_a) mem[wr_r] <= din_a;
    if (push.push_b) mem[addr_b] <= din_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/lgs_checker.sv */
// Port-level checks for the Life generation step unit, bound to the top level.
`timescale 1ns / 1ps
module lgs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [lgs_pkg::MAX_COLS-1:0] out_tdata,
  input logic [lgs_pkg::ROW_W-1:0]  out_tuser,
  input logic                       out_tlast
);
  import lgs_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("stalled result changed");

  // Input backpressure only comes from queued results.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result queue");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

endmodule

bind life_generation_step_unit lgs_checker u_lgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
